>>> design/tat_pkg.sv
// Shared types, constants and helpers for the thermistor temperature block.
`timescale 1ns / 1ps
`default_nettype none

package tat_pkg;

  localparam int unsigned SAMPLES_DEF = 16;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_BETA = 2'd0,
    REG_UNIT = 2'd1,
    REG_HOT  = 2'd2,
    REG_COLD = 2'd3
  } reg_idx_e;

  // Unit codes (anything else reads as Kelvin)
  localparam logic [1:0] UNIT_C = 2'd0;
  localparam logic [1:0] UNIT_F = 2'd1;

  localparam int unsigned CFG_W = 14;

  typedef struct packed {
    logic [13:0]       beta;
    logic [1:0]        unit;
    logic signed [7:0] hot;
    logic signed [7:0] cold;
  } cfg_t;

  // ln 2 in Q30, split for two narrow multiplies
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [14:0] LN2_LO  = LN2_Q30[14:0];
  localparam logic [14:0] LN2_HI  = LN2_Q30[29:15];

  localparam logic [14:0]        T_REF_X100 = 15'd29815;     // 298.15 * 100
  localparam logic signed [15:0] T_REF_S    = 16'sd29815;
  localparam logic [22:0]        BETA_SCALE = 23'd6553600;   // 100 * 2^16
  localparam logic signed [42:0] C0_Q16     = 43'sd17901158; // 273.15 in Q16
  localparam logic signed [47:0] F_OFF_Q16  = 48'sd2097152;  // 32 in Q16
  localparam logic [40:0]        K_CLAMP    = 41'h100_0000_0000;

  // Iterative divider widths
  localparam int unsigned DVD_W = 62;
  localparam int unsigned DVS_W = 40;

  // Position of the top set bit of a nonzero 16-bit value
  function automatic logic [3:0] msb16(input logic [15:0] x);
    logic [3:0] pos;
    pos = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (x[i]) begin
        pos = 4'(i);
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

>>> design/tat_if.sv
// Valid/ready channel interfaces for ADC samples and temperature results.
`timescale 1ns / 1ps
`default_nettype none

interface tat_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

interface tat_out_if;
  logic               valid;
  logic               ready;
  logic signed [13:0] temperature;
  logic               hot_flag;
  logic               cold_flag;
  logic               sensor_fault;

  modport source (output valid, output temperature, output hot_flag, output cold_flag,
                  output sensor_fault, input ready);
  modport sink (input valid, input temperature, input hot_flag, input cold_flag,
                input sensor_fault, output ready);
endinterface

`default_nettype wire

>>> design/thermistor_average_to_temperature.sv
// Top level: NTC thermistor window average to temperature via the beta equation.
//
// Usage:
//   sample_i carries one 16-bit ADC word of the thermistor divider per handshake
//   (valid & ready). Every SAMPLES_PER_AVERAGE-th word closes a window and yields
//   one word on result_o: temperature (signed, selected unit, truncated and
//   saturated to -1024..8191), hot/cold flags and sensor_fault (average of zero).
//   The config port (cfg_we_i, cfg_idx_i, cfg_wdata_i) writes beta, unit,
//   hot and cold thresholds; write it only while the block is idle.
// Timing:
//   Samples are taken one per cycle while sample_i.ready is high. A window sum
//   goes into a two-entry queue; the back end then works through each result
//   with two log2 squaring loops and one pass of the bit-serial divider, plus
//   the Fahrenheit steps in that unit; a zero average skips straight to the result.
// Reset:
//   rst_ni clears the window, queue and result register and loads the register
//   defaults (beta 3950, Celsius, hot 25 C, cold 21 C).
// Backpressure:
//   A finished result sits in the output register until taken; the back end
//   then waits, the queue fills, and sample_i drops ready only on the closing
//   sample of a window when the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module thermistor_average_to_temperature
  import tat_pkg::*;
#(
  parameter int unsigned SAMPLES_PER_AVERAGE = SAMPLES_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  tat_in_if.sink                sample_i,
  tat_out_if.source             result_o,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_idx_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i
);

  localparam int unsigned CNT_W = $clog2(SAMPLES_PER_AVERAGE);
  localparam int unsigned SUM_W = 16 + CNT_W;

  cfg_t             cfg_q;
  logic             push, full, pop, empty;
  logic [SUM_W-1:0] push_data, q_data;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.beta <= 14'd3950;
      cfg_q.unit <= UNIT_C;
      cfg_q.hot  <= 8'sd25;
      cfg_q.cold <= 8'sd21;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_BETA: cfg_q.beta <= cfg_wdata_i;
        REG_UNIT: cfg_q.unit <= cfg_wdata_i[1:0];
        REG_HOT:  cfg_q.hot  <= cfg_wdata_i[7:0];
        REG_COLD: cfg_q.cold <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  tat_front #(
    .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
    .CNT_W               (CNT_W),
    .SUM_W               (SUM_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_i),
    .q_full_i    (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  tat_fifo #(
    .SUM_W (SUM_W)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .data_o      (q_data)
  );

  tat_back #(
    .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
    .CNT_W               (CNT_W),
    .SUM_W               (SUM_W)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_empty_i (empty),
    .q_data_i  (q_data),
    .q_pop_o   (pop),
    .result_o  (result_o)
  );

endmodule

`default_nettype wire

>>> design/tat_front.sv
// Front end: accumulates samples and pushes each finished window sum.
`timescale 1ns / 1ps
`default_nettype none

module tat_front
  import tat_pkg::*;
#(
  parameter int unsigned SAMPLES_PER_AVERAGE = SAMPLES_DEF,
  parameter int unsigned CNT_W = $clog2(SAMPLES_PER_AVERAGE),
  parameter int unsigned SUM_W = 16 + CNT_W
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  tat_in_if.sink       sample_i,
  input  wire logic    q_full_i,
  output logic         push_o,
  output logic [SUM_W-1:0] push_data_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic             last;
  logic             accept;
  logic [SUM_W-1:0] sum_new;

  assign last           = (count_q == CNT_W'(SAMPLES_PER_AVERAGE - 1));
  assign sample_i.ready = !last || !q_full_i;
  assign accept         = sample_i.valid && sample_i.ready;
  assign sum_new        = sum_q + SUM_W'(sample_i.adc_sample);
  assign push_o         = accept && last;
  assign push_data_o    = sum_new;

  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    if (accept) begin
      if (last) begin
        count_d = '0;
        sum_d   = '0;
      end else begin
        count_d = count_q + 1'b1;
        sum_d   = sum_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
    end
  end

endmodule

`default_nettype wire

>>> design/tat_fifo.sv
// Two-entry queue of window sums between front and back end.
`timescale 1ns / 1ps
`default_nettype none

module tat_fifo
  import tat_pkg::*;
#(
  parameter int unsigned SUM_W = 20
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [SUM_W-1:0] push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic [SUM_W-1:0]      data_o
);

  logic [SUM_W-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue underflow");

endmodule

`default_nettype wire

>>> design/tat_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module tat_div
  import tat_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [DVD_W-1:0]      quotient_o
);

  localparam int unsigned CW = $clog2(DVD_W);

  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] rem_q, dvs_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic [DVS_W:0]   shifted, diff;
  logic             ge;

  assign shifted = {rem_q, quo_q[DVD_W-1]};
  assign ge      = (shifted >= {1'b0, dvs_q});
  assign diff    = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        quo_q  <= dividend_i;
        rem_q  <= '0;
        dvs_q  <= divisor_i;
        cnt_q  <= CW'(DVD_W - 1);
      end else if (busy_q) begin
        rem_q <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
        quo_q <= {quo_q[DVD_W-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

>>> design/tat_back.sv
// Back end: average, log2, beta equation, unit conversion and result register.
`timescale 1ns / 1ps
`default_nettype none

module tat_back
  import tat_pkg::*;
#(
  parameter int unsigned SAMPLES_PER_AVERAGE = SAMPLES_DEF,
  parameter int unsigned CNT_W = $clog2(SAMPLES_PER_AVERAGE),
  parameter int unsigned SUM_W = 16 + CNT_W
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_t             cfg_i,
  input  wire logic             q_empty_i,
  input  wire logic [SUM_W-1:0] q_data_i,
  output logic                  q_pop_o,
  tat_out_if.source             result_o
);

  // avg = (sum * RECIP) >> RS, exact for every sum that fits SUM_W bits
  localparam int unsigned RS = SUM_W + CNT_W;
  localparam logic [SUM_W:0] RECIP = (SUM_W + 1)'(((64'd1 << RS) + 64'(SAMPLES_PER_AVERAGE)
                                       - 64'd1) / 64'(SAMPLES_PER_AVERAGE));

  // x / 5 = (x * RECIP5) >> 34, exact for any 32-bit x
  localparam logic [31:0] RECIP5 = 32'hCCCC_CCCD;
  // 9*|C| above this saturates the Fahrenheit result either way
  localparam logic [46:0] F_SAT  = 47'h0000_FFFF_FFFF;

  typedef enum logic [3:0] {
    S_IDLE, S_AVG, S_LINIT, S_LSQ, S_LN1, S_LN2, S_LN3,
    S_DEN1, S_DEN2, S_KDIV, S_CONV, S_FDIV, S_FMUL, S_FOFF, S_FIN
  } state_e;

  state_e             state_q;
  logic [SUM_W-1:0]   sum_q;
  logic [15:0]        avg_q;
  logic               fault_q;
  logic               log_sel_q;
  logic [3:0]         step_q, k_q;
  logic [30:0]        m_q;
  logic [15:0]        frac_q;
  logic [19:0]        la_q, lb_q;
  logic               dneg_q;
  logic [20:0]        dmag_q;
  logic [28:0]        nb_q;
  logic [35:0]        plo_q;
  logic signed [21:0] lq_q;
  logic signed [DVS_W-1:0] den_q;
  logic signed [41:0] kq_q;
  logic signed [42:0] cq_q;
  logic [31:0]        f_x_q;
  logic [29:0]        fq_q;
  logic signed [47:0] vq_q;
  logic               out_valid_q;
  logic signed [13:0] temp_q;
  logic               hot_q, cold_q, fault_out_q;

  // Combinational helpers
  logic [2*SUM_W:0]   avg_prod;
  logic [15:0]        x_sel;
  logic [3:0]         k_init;
  logic [30:0]        m_init;
  logic [61:0]        sq;
  logic [31:0]        sq_sh;
  logic [15:0]        frac_nx;
  logic signed [20:0] d_diff;
  logic [35:0]        phi;
  logic [51:0]        ln_acc;
  logic [20:0]        lmag;
  logic signed [37:0] den_prod;
  logic [36:0]        bterm;
  logic signed [DVS_W-1:0] den_nx;
  logic [DVS_W-1:0]   den_mag;
  logic [40:0]        kmag;
  logic signed [42:0] cq_nx;
  logic signed [46:0] c9;
  logic [46:0]        c9_mag;
  logic [31:0]        f_x_nx;
  logic [63:0]        f_prod;
  logic signed [47:0] fv;
  logic [47:0]        vmag;
  logic [31:0]        tmag;
  logic signed [13:0] t_val;
  logic signed [42:0] hot_q16, cold_q16;
  logic               out_free;

  logic               div_start, div_busy, div_done;
  logic [DVD_W-1:0]   div_dvd, div_quo;
  logic [DVS_W-1:0]   div_dvs;

  always_comb begin
    avg_prod = (2*SUM_W + 1)'(sum_q) * (2*SUM_W + 1)'(RECIP);
    x_sel    = log_sel_q ? avg_q : 16'(17'h10000 - {1'b0, avg_q});
    k_init   = msb16(x_sel);
    m_init   = 31'({15'd0, x_sel} << (5'd30 - {1'b0, k_init}));
    sq       = 62'(m_q) * 62'(m_q);
    sq_sh    = sq[61:30];
    frac_nx  = frac_q;
    frac_nx[step_q] = sq_sh[31];
    d_diff   = $signed({1'b0, la_q}) - $signed({1'b0, lb_q});
    phi      = 36'(dmag_q) * 36'(LN2_HI);
    ln_acc   = {1'b0, phi, 15'd0} + 52'(plo_q);
    lmag     = ln_acc[50:30];
    den_prod = 38'(lq_q) * 38'(T_REF_S);
    bterm    = 37'(cfg_i.beta) * 37'(BETA_SCALE);
    den_nx   = den_q + $signed({3'b000, bterm});
    den_mag  = den_nx[DVS_W-1] ? DVS_W'(-den_nx) : DVS_W'(den_nx);
    kmag     = (div_quo > DVD_W'(K_CLAMP)) ? K_CLAMP : div_quo[40:0];
    cq_nx    = 43'(kq_q) - C0_Q16;
    c9       = ($signed({cq_q, 3'b000}) + 47'(cq_q));
    c9_mag   = c9[46] ? 47'(-c9) : 47'(c9);
    f_x_nx   = (c9_mag > F_SAT) ? 32'hFFFF_FFFF : c9_mag[31:0];
    f_prod   = 64'(f_x_q) * 64'(RECIP5);
    fv       = (cq_q[42] ? -$signed({18'd0, fq_q}) : $signed({18'd0, fq_q})) + F_OFF_Q16;
    vmag     = vq_q[47] ? 48'(-vq_q) : 48'(vq_q);
    tmag     = vmag[47:16];
    if (vq_q[47]) begin
      t_val = (tmag > 32'd1024) ? -14'sd1024 : 14'(-$signed({1'b0, tmag}));
    end else begin
      t_val = (tmag > 32'd8191) ? 14'sd8191 : 14'(tmag);
    end
    hot_q16  = $signed({{19{cfg_i.hot[7]}}, cfg_i.hot, 16'd0});
    cold_q16 = $signed({{19{cfg_i.cold[7]}}, cfg_i.cold, 16'd0});
    out_free = !out_valid_q || result_o.ready;

    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    if (state_q == S_DEN2 && den_nx != '0) begin
      div_start = 1'b1;
      div_dvd   = DVD_W'({nb_q, 32'd0});
      div_dvs   = den_mag;
    end
  end

  assign q_pop_o = (state_q == S_IDLE) && !q_empty_i;

  tat_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
      avg_q       <= '0;
      fault_q     <= 1'b0;
      log_sel_q   <= 1'b0;
      step_q      <= '0;
      k_q         <= '0;
      m_q         <= '0;
      frac_q      <= '0;
      la_q        <= '0;
      lb_q        <= '0;
      dneg_q      <= 1'b0;
      dmag_q      <= '0;
      nb_q        <= '0;
      plo_q       <= '0;
      lq_q        <= '0;
      den_q       <= '0;
      kq_q        <= '0;
      cq_q        <= '0;
      f_x_q       <= '0;
      fq_q        <= '0;
      vq_q        <= '0;
      temp_q      <= '0;
      hot_q       <= 1'b0;
      cold_q      <= 1'b0;
      fault_out_q <= 1'b0;
    end else begin
      // S_FIN drives the valid flag itself
      if (out_valid_q && result_o.ready && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            sum_q   <= q_data_i;
            state_q <= S_AVG;
          end
        end
        S_AVG: begin
          avg_q     <= avg_prod[RS +: 16];
          fault_q   <= (avg_prod[RS +: 16] == 16'd0);
          log_sel_q <= 1'b0;
          state_q   <= (avg_prod[RS +: 16] == 16'd0) ? S_FIN : S_LINIT;
        end
        S_LINIT: begin
          k_q     <= k_init;
          m_q     <= m_init;
          frac_q  <= '0;
          step_q  <= 4'd15;
          state_q <= S_LSQ;
        end
        S_LSQ: begin
          m_q    <= sq_sh[31] ? sq_sh[31:1] : sq_sh[30:0];
          frac_q <= frac_nx;
          step_q <= step_q - 1'b1;
          if (step_q == 4'd0) begin
            if (!log_sel_q) begin
              la_q      <= {k_q, frac_nx};
              log_sel_q <= 1'b1;
              state_q   <= S_LINIT;
            end else begin
              lb_q    <= {k_q, frac_nx};
              state_q <= S_LN1;
            end
          end
        end
        S_LN1: begin
          dneg_q  <= d_diff[20];
          dmag_q  <= d_diff[20] ? 21'(-d_diff) : 21'(d_diff);
          nb_q    <= 29'(cfg_i.beta) * 29'(T_REF_X100);
          state_q <= S_LN2;
        end
        S_LN2: begin
          plo_q   <= 36'(dmag_q) * 36'(LN2_LO);
          state_q <= S_LN3;
        end
        S_LN3: begin
          lq_q    <= dneg_q ? -$signed({1'b0, lmag}) : $signed({1'b0, lmag});
          state_q <= S_DEN1;
        end
        S_DEN1: begin
          den_q   <= DVS_W'(den_prod);
          state_q <= S_DEN2;
        end
        S_DEN2: begin
          den_q <= den_nx;
          if (den_nx == '0) begin
            kq_q    <= 42'($signed({1'b0, K_CLAMP}));
            state_q <= S_CONV;
          end else begin
            state_q <= S_KDIV;
          end
        end
        S_KDIV: begin
          if (div_done) begin
            kq_q    <= den_q[DVS_W-1] ? -$signed({1'b0, kmag}) : $signed({1'b0, kmag});
            state_q <= S_CONV;
          end
        end
        S_CONV: begin
          cq_q <= cq_nx;
          if (cfg_i.unit == UNIT_F) begin
            state_q <= S_FDIV;
          end else begin
            vq_q    <= (cfg_i.unit == UNIT_C) ? 48'(cq_nx) : 48'(kq_q);
            state_q <= S_FIN;
          end
        end
        S_FDIV: begin
          f_x_q   <= f_x_nx;
          state_q <= S_FMUL;
        end
        S_FMUL: begin
          fq_q    <= f_prod[63:34];
          state_q <= S_FOFF;
        end
        S_FOFF: begin
          vq_q    <= fv;
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            fault_out_q <= fault_q;
            temp_q      <= fault_q ? 14'sd0 : t_val;
            hot_q       <= !fault_q && (cq_q >= hot_q16);
            cold_q      <= !fault_q && (cq_q <= cold_q16);
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.temperature  = temp_q;
  assign result_o.hot_flag     = hot_q;
  assign result_o.cold_flag    = cold_q;
  assign result_o.sensor_fault = fault_out_q;

  a_pop_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !q_empty_i) |=> (state_q == S_AVG))
    else $error("queued window not taken up");

  a_fault_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && fault_out_q) |-> (temp_q == 14'sd0 && !hot_q && !cold_q))
    else $error("fault result carries data");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

endmodule

`default_nettype wire
